@@ design/sinaq_pkg.sv @@
package sinaq_pkg;

  // field widths of one item and one result
  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned ANSWER_W = 13;

  // bitmap word geometry
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  localparam int unsigned DEF_SET_SIZE = 4096;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

endpackage

@@ design/sinaq_lsb_find.sv @@
module sinaq_lsb_find (
  input  logic [sinaq_pkg::WORD_W-1:0] bits,
  output logic                         found,
  output logic [sinaq_pkg::BIT_W-1:0]  idx
);

  // priority encoder, lowest set bit wins
  always_comb begin
    found = |bits;
    idx   = '0;
    for (int i = sinaq_pkg::WORD_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = sinaq_pkg::BIT_W'(i);
      end
    end
  end

endmodule

@@ design/set_insert_next_absent_query_unit.sv @@
// keeps a set of integers 0 .. SET_SIZE-1 as a presence bitmap of 64-bit words
// held in one synchronous memory (one write port, one read port, registered read)
//
// input channel (item_valid / item_ready, fields kind and value):
//   kind = insert : marks value present, no result; a read, then a write back of
//                   the word with the bit set; out-of-range values ignored
//   kind = query  : one result on answer, the smallest absent integer >= value,
//                   or SET_SIZE when none; out-of-range values answer SET_SIZE
// output channel (answer_valid / answer_ready, field answer) is a register
//
// a query reads one bitmap word per cycle through the memory read port, starting
// at the word of value, so at most WORD_COUNT words, 64 at the default size
// one item is in work at a time; item_ready is high only while idle, so the next
// item is taken only once the current insert or query is done
//
// reset: a clearing pass writes zero to every word, with item_ready low; the set
// is empty afterwards
// stall: a finished query waits for a held answer to be taken before it loads
// the output register; a new item may be accepted while an answer waits
module set_insert_next_absent_query_unit #(
  parameter int unsigned SET_SIZE = sinaq_pkg::DEF_SET_SIZE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           kind,
  input  logic [sinaq_pkg::VALUE_W-1:0]  value,
  output logic                           answer_valid,
  input  logic                           answer_ready,
  output logic [sinaq_pkg::ANSWER_W-1:0] answer
);

  localparam int unsigned WORD_W     = sinaq_pkg::WORD_W;
  localparam int unsigned BIT_W      = sinaq_pkg::BIT_W;
  localparam int unsigned WORD_COUNT = (SET_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  // wide enough for SET_SIZE itself, for a value, and for word:bit positions
  localparam int unsigned POS_A      = $clog2(SET_SIZE + 1);
  localparam int unsigned POS_B      = (POS_A > sinaq_pkg::ANSWER_W) ? POS_A
                                                                     : sinaq_pkg::ANSWER_W;
  localparam int unsigned POS_W      = (POS_B > WIDX_W + BIT_W + 1) ? POS_B
                                                                    : WIDX_W + BIT_W + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_SCAN
  } state_t;

  state_t                          state;
  logic [WIDX_W-1:0]               cur;        // word under work
  logic [BIT_W-1:0]                bit_off;    // bit of value within its word
  logic                            first;      // first word of a query scan
  logic                            oor;        // value at or above SET_SIZE
  logic [WIDX_W-1:0]               clr_addr;

  // bitmap memory
  logic [WORD_W-1:0]               mem [WORD_COUNT];
  logic                            rd_en;
  logic [WIDX_W-1:0]               rd_addr;
  logic [WORD_W-1:0]               rd_data;
  logic                            wr_en;
  logic [WIDX_W-1:0]               wr_addr;
  logic [WORD_W-1:0]               wr_data;

  logic                            accept;
  logic [POS_W-1:0]                value_ext;
  logic                            in_range;
  logic [WIDX_W-1:0]               value_word;

  logic [WORD_W-1:0]               scan_mask;
  logic [WORD_W-1:0]               free_bits;
  logic                            found;
  logic [BIT_W-1:0]                lsb_idx;
  logic                            cur_last;
  logic                            scan_done;
  logic [POS_W-1:0]                pos;
  logic [POS_W-1:0]                result;
  logic                            slot_free;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  assign value_ext  = POS_W'(value);
  assign in_range   = (value_ext < POS_W'(SET_SIZE));
  assign value_word = value_ext[BIT_W +: WIDX_W];

  // scan side: free bits of the word just read, masked below value on the first word
  assign scan_mask = first ? ({WORD_W{1'b1}} << bit_off) : {WORD_W{1'b1}};
  assign free_bits = ~rd_data & scan_mask;

  sinaq_lsb_find u_lsb (
    .bits  (free_bits),
    .found (found),
    .idx   (lsb_idx)
  );

  assign cur_last  = (cur == WIDX_W'(WORD_COUNT - 1));
  assign scan_done = oor || found || cur_last;
  assign pos       = POS_W'({cur, lsb_idx});

  // a zero past the last valid bit, or no zero at all, answers SET_SIZE
  always_comb begin
    if (!oor && found && (pos < POS_W'(SET_SIZE))) begin
      result = pos;
    end else begin
      result = POS_W'(SET_SIZE);
    end
  end

  assign slot_free = !answer_valid || answer_ready;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data | (WORD_W'(1) << bit_off);
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en   = accept && in_range;
        rd_addr = value_word;
      end
      S_INS: begin
        wr_en = !oor;
      end
      S_SCAN: begin
        rd_en   = !scan_done;
        rd_addr = cur + WIDX_W'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      answer_valid <= 1'b0;
      first        <= 1'b0;
      oor          <= 1'b0;
    end else begin
      if (answer_valid && answer_ready) begin
        answer_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WIDX_W'(1);
          if (clr_addr == WIDX_W'(WORD_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur     <= value_word;
            bit_off <= value[BIT_W-1:0];
            first   <= 1'b1;
            oor     <= !in_range;
            state   <= (kind == sinaq_pkg::KIND_INSERT) ? S_INS : S_SCAN;
          end
        end
        S_INS: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_done) begin
            // hold here, read data unchanged, until the output register frees up
            if (slot_free) begin
              answer       <= result[sinaq_pkg::ANSWER_W-1:0];
              answer_valid <= 1'b1;
              state        <= S_IDLE;
            end
          end else begin
            cur   <= cur + WIDX_W'(1);
            first <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/sinaq_checker.sv @@
module sinaq_checker #(
  parameter int unsigned SET_SIZE = sinaq_pkg::DEF_SET_SIZE
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           kind,
  input logic [sinaq_pkg::VALUE_W-1:0]  value,
  input logic                           answer_valid,
  input logic                           answer_ready,
  input logic [sinaq_pkg::ANSWER_W-1:0] answer
);

  // held answer stays put
  a_answer_hold: assert property (@(posedge clk) disable iff (rst)
    answer_valid && !answer_ready |=> answer_valid && $stable(answer))
    else $error("answer changed or dropped while stalled");

  // never beyond SET_SIZE; checked when SET_SIZE < 8192
  a_answer_range: assert property (@(posedge clk) disable iff (rst)
    answer_valid |-> (SET_SIZE >= 8192) || (answer <= SET_SIZE))
    else $error("answer above set size");

  // insert does its read-modify-write before the next item
  a_insert_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (kind == sinaq_pkg::KIND_INSERT) |=> !item_ready)
    else $error("item taken during insert write-back");

  // answer_valid low at a query's accept stays low next cycle
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (kind == sinaq_pkg::KIND_QUERY) && !answer_valid
    |=> !answer_valid)
    else $error("query answered too early");

  // reset starts the clearing pass with nothing shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !answer_valid && !item_ready)
    else $error("block not quiet after reset");

endmodule

bind set_insert_next_absent_query_unit sinaq_checker #(.SET_SIZE(SET_SIZE)) u_checker (.*);
